>>> hdl/apafe_pkg.sv
// Package for the LED frame encoder: command codes, queue entry type and
// frame constants. Depends on nothing; every other file imports it.
`default_nettype none

package apafe_pkg;

  // Field widths of the item channels.
  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned SampleWidth = 8;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LedSelWidth = 4;
  localparam int unsigned ChSelWidth  = 2;
  localparam int unsigned BrightWidth = 5;

  // Frame layout constants.
  localparam logic [ByteWidth-1:0] HeaderMark = 8'hE0;
  localparam logic [ByteWidth-1:0] ZeroByte   = 8'h00;
  localparam int unsigned StartBytes  = 4;
  localparam int unsigned EndDivisor  = 16;
  localparam int unsigned NumChannels = 3;

  // Queue between the front and the back.
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCountW = 2;

  // Configuration register map.
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic RegBrightness = 1'b0;  // word index of the brightness register

  typedef enum logic [CmdWidth-1:0] {
    CmdSample  = 2'd0,
    CmdChannel = 2'd1,
    CmdLed     = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [ChSelWidth-1:0] {
    ChRed   = 2'd0,
    ChGreen = 2'd1,
    ChBlue  = 2'd2,
    ChSpare = 2'd3
  } chan_e;

  // One sample write plus frame request, as handed from front to back.
  typedef struct packed {
    logic [LedSelWidth-1:0] led;
    logic [ChSelWidth-1:0]  chan;
    logic [SampleWidth-1:0] sample;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/apafe_in_if.sv
// Input item channel of the LED frame encoder: command and sample.
// Depends on apafe_pkg.
`default_nettype none

interface apafe_in_if
  import apafe_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CmdWidth-1:0]    command;
  logic [SampleWidth-1:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

`default_nettype wire

>>> hdl/apafe_out_if.sv
// Output item channel of the LED frame encoder: frame byte and last flag.
// Depends on apafe_pkg.
`default_nettype none

interface apafe_out_if
  import apafe_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] frame_byte;
  logic                 last;

  modport source (output valid, output frame_byte, output last, input ready);
  modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/apa102_channel_edit_frame_encoder_unit.sv
// Top level of the APA102 channel-edit frame encoder.
// Depends on apafe_pkg, apafe_in_if, apafe_out_if, apafe_front, apafe_queue, apafe_back.
//
// Usage: items arrive on in_i with a command and a sample. A channel button
// command steps the selected color channel, an LED button command steps the
// selected LED and returns the channel to red; each button counts only on
// every other press. A sample command stores the sample in the selected
// channel of the selected LED and then streams a full APA102 frame on out_o,
// one byte per item, with last set on the final byte.
// Flow: a sample item is taken and queued; the streamer pops it into its send
// state and each frame byte then passes through the output register to out_o.
// The streamer takes one queued request at a time and then emits one byte per
// cycle while out_o is ready; it takes the next request only once the frame of
// 4 + 4*NUM_LEDS + ceil(NUM_LEDS/16) bytes is done. Button items emit nothing.
// A two-entry queue lies between the front and the streamer, so inputs keep
// being taken while a frame is in flight until the queue fills.
// Stalls: when out_o is not ready the current byte holds in the output
// register and the streamer waits; in_i drops ready only when the queue is full.
// Reset: all color values clear to zero, both selectors to red / LED 0,
// both parity flags to one, brightness to 1, and the queue empties.
// Brightness is written through the APB port at byte address 0.
`default_nettype none

module apa102_channel_edit_frame_encoder_unit
  import apafe_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  apafe_in_if.sink                  in_i,
  apafe_out_if.source               out_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output      logic [DataWidth-1:0] prdata,
  output      logic                 pready
);

  // Global brightness register. The word index is the top address bit;
  // writes to any other word are ignored.
  logic [BrightWidth-1:0] bright_q;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[AddrWidth-1] == RegBrightness);
  assign prdata    = (paddr[AddrWidth-1] == RegBrightness)
                   ? {{(DataWidth-BrightWidth){1'b0}}, bright_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BrightWidth'(1);
    end else if (cfg_write) begin
      bright_q <= pwdata[BrightWidth-1:0];
    end
  end

  // Front: command decode and selector state; hands sample writes to the queue.
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_in, q_out;

  apafe_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_command_i (in_i.command),
    .in_sample_i  (in_i.sample),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_in)
  );

  apafe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  // Back: applies the write to the color store, then streams the frame.
  apafe_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bright_i    (bright_q),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.frame_byte),
    .out_last_o  (out_o.last)
  );

endmodule

`default_nettype wire

>>> hdl/apafe_front.sv
// Front of the LED frame encoder: takes items, keeps the selectors and the
// button parity flags, and queues sample writes. Depends on apafe_pkg.
`default_nettype none

module apafe_front
  import apafe_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [CmdWidth-1:0]    in_command_i,
  input  wire logic [SampleWidth-1:0] in_sample_i,
  input  wire logic                   q_full_i,
  output      logic                   q_push_o,
  output      entry_t                 q_entry_o
);

  logic [ChSelWidth-1:0]  chan_q, chan_d;
  logic [LedSelWidth-1:0] led_q, led_d;
  logic                   chan_par_q, chan_par_d;
  logic                   led_par_q, led_par_d;
  logic                   accept;
  cmd_e                   cmd;
  logic [ChSelWidth:0]    chan_inc;
  logic [LedSelWidth:0]   led_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cmd        = cmd_e'(in_command_i);
  assign chan_inc   = {1'b0, chan_q} + 1'b1;
  assign led_inc    = {1'b0, led_q} + 1'b1;

  always_comb begin
    chan_d     = chan_q;
    led_d      = led_q;
    chan_par_d = chan_par_q;
    led_par_d  = led_par_q;
    q_push_o   = 1'b0;
    if (accept) begin
      unique case (cmd)
        CmdChannel: begin
          if (chan_par_q) begin
            chan_d = (chan_inc >= (ChSelWidth+1)'(NumChannels)) ? ChRed
                                                                : chan_inc[ChSelWidth-1:0];
          end
          chan_par_d = !chan_par_q;
        end
        CmdLed: begin
          if (led_par_q) begin
            led_d  = (led_inc >= (LedSelWidth+1)'(NUM_LEDS)) ? '0
                                                             : led_inc[LedSelWidth-1:0];
            chan_d = ChRed;
          end
          led_par_d = !led_par_q;
        end
        CmdSample: q_push_o = 1'b1;
        default:   ;
      endcase
    end
  end

  assign q_entry_o = '{led: led_q, chan: chan_q, sample: in_sample_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= ChRed;
      led_q      <= '0;
      chan_par_q <= 1'b1;
      led_par_q  <= 1'b1;
    end else begin
      chan_q     <= chan_d;
      led_q      <= led_d;
      chan_par_q <= chan_par_d;
      led_par_q  <= led_par_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/apafe_queue.sv
// Two-entry queue of pending sample writes between front and back of the
// LED frame encoder. Depends on apafe_pkg.
`default_nettype none

module apafe_queue
  import apafe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output      logic   full_o,
  input  wire logic   pop_i,
  output      logic   empty_o,
  output      entry_t entry_o
);

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCountW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCountW'(QDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    priority if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/apafe_back.sv
// Back of the LED frame encoder: applies queued sample writes to the color
// store and streams the frame bytes. Depends on apafe_pkg.
`default_nettype none

module apafe_back
  import apafe_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [BrightWidth-1:0] bright_i,
  input  wire logic                   q_empty_i,
  input  wire entry_t                 q_entry_i,
  output      logic                   q_pop_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [ByteWidth-1:0]   out_byte_o,
  output      logic                   out_last_o
);

  localparam int unsigned LedBytes   = 4 * NUM_LEDS;
  localparam int unsigned EndBytes   = (NUM_LEDS + EndDivisor - 1) / EndDivisor;
  localparam int unsigned FrameBytes = StartBytes + LedBytes + EndBytes;
  localparam int unsigned CntW       = $clog2(FrameBytes);
  localparam int unsigned LedIdxW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  typedef enum logic {
    StIdle,
    StSend
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        cnt_q;
  logic                   valid_q, valid_d;
  logic [ByteWidth-1:0]   byte_q;
  logic                   last_q;
  logic [ByteWidth-1:0]   colors_q [NUM_LEDS][NumChannels];

  logic                   out_free;
  logic                   emit;
  logic                   write_en;
  logic [LedIdxW-1:0]     wr_idx;
  logic [CntW-1:0]        rel;
  logic [LedIdxW-1:0]     rd_idx;
  logic [1:0]             sub;
  logic [ByteWidth-1:0]   gen_byte;
  logic                   gen_last;

  assign out_free = !valid_q || out_ready_i;
  assign q_pop_o  = (state_q == StIdle) && !q_empty_i;
  assign emit     = (state_q == StSend) && out_free;

  // A write to an LED or channel outside the store is dropped; the frame still goes out.
  assign write_en = q_pop_o && (q_entry_i.led < LedSelWidth'(NUM_LEDS))
                            && (q_entry_i.chan < ChSelWidth'(NumChannels));
  assign wr_idx   = q_entry_i.led[LedIdxW-1:0];

  assign rel      = cnt_q - CntW'(StartBytes);
  assign rd_idx   = LedIdxW'(rel >> 2);
  assign sub      = rel[1:0];
  assign gen_last = (cnt_q == CntW'(FrameBytes - 1));

  // The output register empties when taken and refills on every emitted byte.
  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (emit) valid_d = 1'b1;
  end

  always_comb begin
    gen_byte = ZeroByte;
    if (cnt_q >= CntW'(StartBytes) && cnt_q < CntW'(StartBytes + LedBytes)) begin
      unique case (sub)
        2'd0: gen_byte = HeaderMark | {{(ByteWidth-BrightWidth){1'b0}}, bright_i};
        2'd1: gen_byte = colors_q[rd_idx][ChBlue];
        2'd2: gen_byte = colors_q[rd_idx][ChGreen];
        2'd3: gen_byte = colors_q[rd_idx][ChRed];
        default: gen_byte = ZeroByte;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      unique case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            state_q <= StSend;
            cnt_q   <= '0;
          end
        end
        StSend: begin
          if (out_free) begin
            cnt_q <= cnt_q + 1'b1;
            if (gen_last) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= gen_byte;
      last_q <= gen_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        for (int c = 0; c < NumChannels; c++) begin
          colors_q[i][c] <= ZeroByte;
        end
      end
    end else if (write_en) begin
      colors_q[wr_idx][q_entry_i.chan] <= q_entry_i.sample;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire
